// ----- rtl/core/stgpe_pkg.sv -----
// Shared types and constants for the sector-to-group packet encoder.
// No dependencies; imported by the encoder core and its port checker.
package stgpe_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned POS_W        = $clog2(SECTOR_BYTES);
  localparam int unsigned GROUP_LEN    = 7;
  localparam int unsigned HOLD_DEPTH   = GROUP_LEN - 1;
  localparam int unsigned PHASE_W      = $clog2(GROUP_LEN);
  localparam int unsigned IDX_W        = 4;

  localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(SECTOR_BYTES - 1);
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(GROUP_LEN - 1);

  // Last beat index of each burst kind
  localparam logic [IDX_W-1:0] LEAD_LAST_IDX      = 4'd15;
  localparam logic [IDX_W-1:0] GROUP_LAST_IDX     = 4'd7;
  localparam logic [IDX_W-1:0] GROUP_END_LAST_IDX = 4'd10;

  // Sync run and begin byte
  localparam logic [7:0] LEAD_SEQ [0:6] = '{8'hFF, 8'h3F, 8'hCF, 8'hF3, 8'hFC, 8'hFF, 8'hC3};

  // Header bytes (source id sits between HDR_A and HDR_B)
  localparam logic [7:0] HDR_A = 8'h80;
  localparam logic [7:0] HDR_B = 8'h82;
  localparam logic [7:0] HDR_C = 8'h80;
  localparam logic [7:0] HDR_D = 8'h80;
  localparam logic [7:0] HDR_E = 8'h81;
  localparam logic [7:0] HDR_F = 8'hC9;
  localparam logic [7:0] HDR_FIXED_XOR = HDR_A ^ HDR_B ^ HDR_C ^ HDR_D ^ HDR_E ^ HDR_F;

  localparam logic [7:0] TOP_BIT    = 8'h80;
  localparam logic [7:0] SUM_FILL   = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'hC8;

  typedef enum logic [1:0] {
    BK_LEAD,
    BK_GROUP,
    BK_GROUP_END
  } burst_kind_t;

endpackage

// ----- rtl/core/sector_to_group_packet_encoder.sv -----
// Sector-to-group packet encoder: sector bytes in, 7-to-8 encoded packet bytes out.
// Depends on stgpe_pkg (constants, burst kind enum).
//
//  channel | ports                                   | direction | beat
//  in      | in_valid, in_stall, in_data_byte,       | into core | one sector byte
//          | in_source_id                            |           |
//  out     | out_valid, out_stall, out_packet_byte,  | from core | one packet byte
//          | out_end_of_packet                       |           |
//
// Timing:
//  - Sector byte 0 opens a 16-beat burst, the seventh byte of each group an
//    8-beat burst, byte 511 an 11-beat burst; other bytes produce no beats.
//  - The out register sends one beat per cycle while out_stall is low; a new burst
//    is loaded in the cycle the previous burst's last beat leaves, so the burst
//    register plus output register set the rate: about 8 beats per 7 sector bytes.
//  - Bytes that produce no beats are taken every cycle, even while a burst drains.
//  - Reset (rst_n low, synchronous) clears position, checksum and all valid flags.
//  - A stalled out beat holds; the burst behind it waits and stalls the input
//    only when the next input byte would itself start a burst.
module sector_to_group_packet_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_source_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_packet_byte,
  output logic       out_end_of_packet
);
  import stgpe_pkg::*;

  // Sector state
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]         csum_r, csum_nxt;
  logic [7:0]         hold_r [HOLD_DEPTH];

  // Burst register: everything needed to replay one item's beats
  logic               burst_valid_r, burst_valid_nxt;
  burst_kind_t        burst_kind_r;
  logic [IDX_W-1:0]   burst_last_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [7:0]         burst_data_r;
  logic [7:0]         burst_src_r;
  logic [7:0]         burst_sum_r;
  logic [7:0]         burst_hold_r [HOLD_DEPTH];

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r;
  logic               out_eop_r;

  logic               at_start, needs_burst, emit, burst_done, in_fire;
  logic [7:0]         beat_byte;
  logic               beat_eop;
  logic [PHASE_W-1:0] hold_sel;

  // A byte starts a burst when it opens the sector or closes a group
  assign at_start    = (pos_r == '0);
  assign needs_burst = at_start || (phase_r == LAST_PHASE);

  assign emit       = burst_valid_r && (!out_valid_r || !out_stall);
  assign burst_done = emit && (idx_r == burst_last_r);

  // Stall only a burst-starting byte, and only while the current burst drains
  assign in_stall = needs_burst && burst_valid_r && !burst_done;
  assign in_fire  = in_valid && !in_stall;

  // Sector position, group phase and checksum
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    csum_nxt  = csum_r;
    if (in_fire) begin
      if (at_start) begin
        pos_nxt   = POS_W'(1);
        phase_nxt = '0;
        csum_nxt  = in_source_id ^ HDR_FIXED_XOR ^ in_data_byte;
      end else begin
        phase_nxt = (phase_r == LAST_PHASE) ? '0 : phase_r + PHASE_W'(1);
        if (pos_r == LAST_POS) begin
          // Packet closes: restart position and checksum for the next sector
          pos_nxt  = '0;
          csum_nxt = '0;
        end else begin
          pos_nxt  = pos_r + POS_W'(1);
          csum_nxt = csum_r ^ in_data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= '0;
      csum_r  <= '0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      csum_r  <= csum_nxt;
    end
  end

  // Park the first six bytes of a group until the seventh arrives
  always_ff @(posedge clk) begin
    if (in_fire && !at_start && (phase_r != LAST_PHASE)) begin
      hold_r[phase_r] <= in_data_byte;
    end
  end

  // Burst control: advance the beat index, free the register on the last beat
  always_comb begin
    burst_valid_nxt = burst_valid_r && !burst_done;
    idx_nxt         = idx_r;
    if (emit && !burst_done) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (in_fire && needs_burst) begin
      burst_valid_nxt = 1'b1;
      idx_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_valid_r <= 1'b0;
      idx_r         <= '0;
    end else begin
      burst_valid_r <= burst_valid_nxt;
      idx_r         <= idx_nxt;
    end
  end

  // Burst payload: snapshot the item and the group so the next group can fill
  always_ff @(posedge clk) begin
    if (in_fire && needs_burst) begin
      burst_data_r <= in_data_byte;
      burst_src_r  <= in_source_id;
      burst_sum_r  <= csum_r ^ in_data_byte;
      burst_hold_r <= hold_r;
      if (at_start) begin
        burst_kind_r <= BK_LEAD;
        burst_last_r <= LEAD_LAST_IDX;
      end else if (pos_r == LAST_POS) begin
        burst_kind_r <= BK_GROUP_END;
        burst_last_r <= GROUP_END_LAST_IDX;
      end else begin
        burst_kind_r <= BK_GROUP;
        burst_last_r <= GROUP_LAST_IDX;
      end
    end
  end

  // Beat selection for the current burst index
  assign hold_sel = PHASE_W'(idx_r - IDX_W'(1));

  always_comb begin
    beat_byte = burst_data_r | TOP_BIT;
    beat_eop  = 1'b0;
    unique case (burst_kind_r)
      BK_LEAD: begin
        unique case (idx_r)
          4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: beat_byte = LEAD_SEQ[idx_r[2:0]];
          4'd7:  beat_byte = HDR_A;
          4'd8:  beat_byte = burst_src_r;
          4'd9:  beat_byte = HDR_B;
          4'd10: beat_byte = HDR_C;
          4'd11: beat_byte = HDR_D;
          4'd12: beat_byte = HDR_E;
          4'd13: beat_byte = HDR_F;
          4'd14: beat_byte = {1'b1, burst_data_r[7], 6'b0};
          default: beat_byte = burst_data_r | TOP_BIT;
        endcase
      end
      BK_GROUP, BK_GROUP_END: begin
        priority if (idx_r == '0) begin
          // Gather the seven top bits, first byte of the group highest
          beat_byte = {1'b1, burst_hold_r[0][7], burst_hold_r[1][7], burst_hold_r[2][7],
                       burst_hold_r[3][7], burst_hold_r[4][7], burst_hold_r[5][7],
                       burst_data_r[7]};
        end else if (idx_r <= IDX_W'(HOLD_DEPTH)) begin
          beat_byte = burst_hold_r[hold_sel] | TOP_BIT;
        end else if (idx_r == IDX_W'(GROUP_LEN)) begin
          beat_byte = burst_data_r | TOP_BIT;
        end else if (idx_r == IDX_W'(GROUP_LEN + 1)) begin
          beat_byte = burst_sum_r | SUM_FILL;
        end else if (idx_r == IDX_W'(GROUP_LEN + 2)) begin
          beat_byte = {1'b0, burst_sum_r[7:1]} | SUM_FILL;
        end else begin
          beat_byte = END_BYTE;
          beat_eop  = 1'b1;
        end
      end
      default: begin
        beat_byte = burst_data_r | TOP_BIT;
        beat_eop  = 1'b0;
      end
    endcase
  end

  // Output register: load on emit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= beat_byte;
      out_eop_r  <= beat_eop;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_byte   = out_byte_r;
  assign out_end_of_packet = out_eop_r;

endmodule

// ----- rtl/core/stgpe_checker.sv -----
// Port-level checker for the sector-to-group packet encoder, bound to the top level.
// Depends on stgpe_pkg (END_BYTE).
module stgpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_packet_byte,
  input logic       out_end_of_packet
);
  import stgpe_pkg::*;

  // Reset empties the output and frees the input
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stall right after reset");

  // The end flag marks only the end byte
  a_eop_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_packet |-> out_packet_byte == END_BYTE)
    else $error("end of packet flagged on a byte other than the end byte");

  // A stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_packet_byte)
                               && $stable(out_end_of_packet))
    else $error("stalled output beat changed");

  // The beat after an end byte opens a new packet, never a second end byte
  a_eop_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_end_of_packet |=> !(out_valid && out_end_of_packet))
    else $error("end of packet flagged on two beats in a row");

endmodule

bind sector_to_group_packet_encoder stgpe_checker u_stgpe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_packet_byte   (out_packet_byte),
  .out_end_of_packet (out_end_of_packet)
);
